### rtl/snop_pkg.sv
`default_nettype none
package snop_pkg;
    // the larger normalized magnitude lies in [2^NORM_MSB, 2^(NORM_MSB+1))
    localparam int NORM_MSB   = 29;
    localparam int NORM_W     = NORM_MSB + 1;
    localparam int SQ_W       = 2 * NORM_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int REM_W      = SUM_W + 2;
    localparam int ROOT_W     = 31;
    localparam int DIV_W      = 64;
    localparam int SHIFT_W    = 6;

    typedef logic [REM_W-1:0]  t_rem;
    typedef logic [ROOT_W-1:0] t_root;
    typedef logic [DIV_W-1:0]  t_div;
endpackage
`default_nettype wire

### rtl/snop_sqrt_cell.sv
`default_nettype none
module snop_sqrt_cell #(
    parameter int BIT = 0
) (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  snop_pkg::t_rem      i_rem,
    input  snop_pkg::t_root     i_root,
    output snop_pkg::t_rem      o_rem,
    output snop_pkg::t_root     o_root
);
    snop_pkg::t_rem  r_rem, n_rem;
    snop_pkg::t_root r_root, n_root;
    snop_pkg::t_rem  trial;
    logic            fits;

    // (root + 2^bit)^2 - root^2
    always_comb begin
        trial  = (snop_pkg::t_rem'(i_root) << (BIT + 1))
               | (snop_pkg::t_rem'(1) << (2 * BIT));
        fits   = i_rem >= trial;
        n_rem  = fits ? i_rem - trial : i_rem;
        n_root = fits ? (i_root | (snop_pkg::t_root'(1) << BIT)) : i_root;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule
`default_nettype wire

### rtl/snop_div_cell.sv
`default_nettype none
module snop_div_cell #(
    parameter int BIT = 0,
    parameter int QW  = 9
) (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  snop_pkg::t_div      i_rem,
    input  snop_pkg::t_div      i_dvs,
    input  wire [QW-1:0]        i_quo,
    output snop_pkg::t_div      o_rem,
    output snop_pkg::t_div      o_dvs,
    output logic [QW-1:0]       o_quo
);
    snop_pkg::t_div r_rem, r_dvs, n_rem, trial;
    logic [QW-1:0]  r_quo, n_quo;
    logic           fits;

    always_comb begin
        trial = i_dvs << BIT;
        fits  = i_rem >= trial;
        n_rem = fits ? i_rem - trial : i_rem;
        n_quo = fits ? (i_quo | (QW'(1) << BIT)) : i_quo;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_dvs <= i_dvs;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_dvs = r_dvs;
    assign o_quo = r_quo;
endmodule
`default_nettype wire

### rtl/segment_normal_offset_points.sv
// Segment normal offset: one segment per clock while the output register is
// not stalled, fully pipelined. An item passes through four setup stages
// (differences, normalizing shift, squares, sum), a row of 31 square-root
// cells producing one root bit each, a row of FRACTION_BITS+1 divider cells per
// normal component, and the rounding/saturation output register. The whole
// pipeline advances whenever the output register is empty or being taken,
// so o_in_ready follows i_out_ready while a result waits.
`default_nettype none
module segment_normal_offset_points #(
    parameter int COORD_WIDTH   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire signed [COORD_WIDTH-1:0] i_start_x,
    input  wire signed [COORD_WIDTH-1:0] i_start_y,
    input  wire signed [COORD_WIDTH-1:0] i_end_x,
    input  wire signed [COORD_WIDTH-1:0] i_end_y,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0] o_left_x,
    output logic signed [COORD_WIDTH-1:0] o_left_y,
    output logic signed [COORD_WIDTH-1:0] o_right_x,
    output logic signed [COORD_WIDTH-1:0] o_right_y,
    output logic                         o_zero_length
);
    localparam int CW   = COORD_WIDTH;
    localparam int MW   = CW + 1;
    localparam int QW   = FRACTION_BITS + 1;
    localparam int DW   = ((CW > FRACTION_BITS) ? CW : FRACTION_BITS) + 3;
    localparam int NRT  = snop_pkg::ROOT_W;
    localparam int NSTG = 4 + NRT + QW + 1;
    localparam int NW   = snop_pkg::NORM_W;

    typedef struct packed {
        logic signed [MW-1:0] sx;
        logic signed [MW-1:0] sy;
        logic                 neg_x;
        logic                 neg_y;
        logic                 zero;
        logic [NW-1:0]        axn;
        logic [NW-1:0]        ayn;
    } t_side;

    logic en;
    logic [NSTG-1:0] r_vld;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end
    assign o_out_valid = r_vld[NSTG-1];

    // stage 1: differences, sums, magnitudes
    t_side         r_sb1, n_sb1;
    logic [MW-1:0] r_ax1, r_ay1, n_ax1, n_ay1;
    logic signed [MW-1:0] dx, dy;

    always_comb begin
        dx = MW'(i_end_x) - MW'(i_start_x);
        dy = MW'(i_end_y) - MW'(i_start_y);
        n_sb1       = '0;
        n_sb1.sx    = MW'(i_start_x) + MW'(i_end_x);
        n_sb1.sy    = MW'(i_start_y) + MW'(i_end_y);
        n_sb1.neg_x = dx[MW-1];
        n_sb1.neg_y = dy[MW-1];
        n_sb1.zero  = (dx == '0) && (dy == '0);
        n_ax1 = dx[MW-1] ? MW'(-dx) : MW'(dx);
        n_ay1 = dy[MW-1] ? MW'(-dy) : MW'(dy);
    end

    // stage 2: normalizing shift
    t_side r_sb2, n_sb2;
    logic [MW-1:0]              mx;
    logic [snop_pkg::SHIFT_W-1:0] msb;
    logic [63:0]                wx, wy;

    always_comb begin
        mx  = (r_ax1 > r_ay1) ? r_ax1 : r_ay1;
        msb = '0;
        for (int i = 0; i < MW; i++) begin
            if (mx[i]) msb = snop_pkg::SHIFT_W'(i);
        end
        wx = 64'(r_ax1);
        wy = 64'(r_ay1);
        n_sb2 = r_sb1;
        if (msb <= snop_pkg::SHIFT_W'(snop_pkg::NORM_MSB)) begin
            n_sb2.axn = NW'(wx << (snop_pkg::SHIFT_W'(snop_pkg::NORM_MSB) - msb));
            n_sb2.ayn = NW'(wy << (snop_pkg::SHIFT_W'(snop_pkg::NORM_MSB) - msb));
        end else begin
            n_sb2.axn = NW'(wx >> (msb - snop_pkg::SHIFT_W'(snop_pkg::NORM_MSB)));
            n_sb2.ayn = NW'(wy >> (msb - snop_pkg::SHIFT_W'(snop_pkg::NORM_MSB)));
        end
    end

    // stage 3: squares, stage 4: sum
    t_side r_sb3, r_sb4;
    logic [snop_pkg::SQ_W-1:0]  r_sqx, r_sqy;
    logic [snop_pkg::SUM_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb1 <= n_sb1;
            r_ax1 <= n_ax1;
            r_ay1 <= n_ay1;
            r_sb2 <= n_sb2;
            r_sqx <= snop_pkg::SQ_W'(r_sb2.axn) * snop_pkg::SQ_W'(r_sb2.axn);
            r_sqy <= snop_pkg::SQ_W'(r_sb2.ayn) * snop_pkg::SQ_W'(r_sb2.ayn);
            r_sb3 <= r_sb2;
            r_sum <= snop_pkg::SUM_W'(r_sqx) + snop_pkg::SUM_W'(r_sqy);
            r_sb4 <= r_sb3;
        end
    end

    // square root row, most significant root bit first
    snop_pkg::t_rem  rem_c  [NRT+1];
    snop_pkg::t_root root_c [NRT+1];
    t_side           r_sbq  [NRT+1];

    assign rem_c[0]  = snop_pkg::t_rem'(r_sum);
    assign root_c[0] = '0;
    always_comb r_sbq[0] = r_sb4;

    for (genvar k = 0; k < NRT; k++) begin : g_sqrt
        snop_sqrt_cell #(.BIT(NRT - 1 - k)) u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (rem_c[k]),
            .i_root (root_c[k]),
            .o_rem  (rem_c[k+1]),
            .o_root (root_c[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (en) r_sbq[k+1] <= r_sbq[k];
        end
    end

    // divider rows for both normal components
    snop_pkg::t_div drx [QW+1];
    snop_pkg::t_div dry [QW+1];
    snop_pkg::t_div dvx [QW+1];
    snop_pkg::t_div dvy [QW+1];
    logic [QW-1:0]  qx  [QW+1];
    logic [QW-1:0]  qy  [QW+1];
    t_side          r_sbd [QW+1];
    snop_pkg::t_div len;

    assign len    = snop_pkg::t_div'(root_c[NRT]);
    assign drx[0] = (snop_pkg::t_div'(r_sbq[NRT].axn) << QW) + len;
    assign dry[0] = (snop_pkg::t_div'(r_sbq[NRT].ayn) << QW) + len;
    assign dvx[0] = len << 1;
    assign dvy[0] = len << 1;
    assign qx[0]  = '0;
    assign qy[0]  = '0;
    always_comb r_sbd[0] = r_sbq[NRT];

    for (genvar k = 0; k < QW; k++) begin : g_div
        snop_div_cell #(.BIT(QW - 1 - k), .QW(QW)) u_dx (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (drx[k]),
            .i_dvs (dvx[k]),
            .i_quo (qx[k]),
            .o_rem (drx[k+1]),
            .o_dvs (dvx[k+1]),
            .o_quo (qx[k+1])
        );
        snop_div_cell #(.BIT(QW - 1 - k), .QW(QW)) u_dy (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (dry[k]),
            .i_dvs (dvy[k]),
            .i_quo (qy[k]),
            .o_rem (dry[k+1]),
            .o_dvs (dvy[k+1]),
            .o_quo (qy[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (en) r_sbd[k+1] <= r_sbd[k];
        end
    end

    // rounding halve and saturate
    function automatic logic signed [CW-1:0] finish(input logic signed [DW-1:0] d);
        logic signed [DW-1:0] v;
        logic signed [DW-1:0] lo, hi;
        v  = (d + DW'(1)) >>> 1;
        lo = -(DW'(1) <<< (CW - 1));
        hi = (DW'(1) <<< (CW - 1)) - DW'(1);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return CW'(v);
    endfunction

    t_side              sbf;
    logic signed [DW-1:0] hx, hy, sxw, syw;

    always_comb begin
        sbf = r_sbd[QW];
        hx  = DW'(qx[QW]);
        hy  = DW'(qy[QW]);
        if (sbf.neg_x) hx = -hx;
        if (sbf.neg_y) hy = -hy;
        if (sbf.zero) begin
            hx = '0;
            hy = '0;
        end
        sxw = DW'(sbf.sx);
        syw = DW'(sbf.sy);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_left_x      <= finish(sxw - hy);
            o_left_y      <= finish(syw + hx);
            o_right_x     <= finish(sxw + hy);
            o_right_y     <= finish(syw - hx);
            o_zero_length <= sbf.zero;
        end
    end
endmodule
`default_nettype wire

### rtl/snop_checker.sv
`default_nettype none
module snop_checker #(
    parameter int COORD_WIDTH = 16
) (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   o_in_ready,
    input wire                   o_out_valid,
    input wire                   i_out_ready,
    input wire [COORD_WIDTH-1:0] o_left_x,
    input wire [COORD_WIDTH-1:0] o_left_y,
    input wire [COORD_WIDTH-1:0] o_right_x,
    input wire [COORD_WIDTH-1:0] o_right_y,
    input wire                   o_zero_length
);
    // a waiting word holds its valid, left x and right y
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_left_x)
            && $stable(o_right_y))
        else $error("output word changed while stalled");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_length |->
            o_left_x == o_right_x && o_left_y == o_right_y)
        else $error("zero-length segment gave distinct points");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
endmodule

bind segment_normal_offset_points snop_checker #(.COORD_WIDTH(COORD_WIDTH)) u_snop_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_left_x      (o_left_x),
    .o_left_y      (o_left_y),
    .o_right_x     (o_right_x),
    .o_right_y     (o_right_y),
    .o_zero_length (o_zero_length)
);
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    localparam int CW = 16;
    localparam int FB = 8;
    localparam int RANDOM_WORDS = 1000;
    localparam int TAIL_WORDS = 150;
    localparam longint CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
    } segment_t;

    typedef struct packed {
        logic signed [CW-1:0] lx;
        logic signed [CW-1:0] ly;
        logic signed [CW-1:0] rx;
        logic signed [CW-1:0] ry;
        logic zero;
    } offsets_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [CW-1:0] i_start_x = '0;
    logic signed [CW-1:0] i_start_y = '0;
    logic signed [CW-1:0] i_end_x = '0;
    logic signed [CW-1:0] i_end_y = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [CW-1:0] o_left_x, o_left_y, o_right_x, o_right_y;
    logic o_zero_length;

    segment_t pending_segments[$];
    offsets_t expected_offsets[$];
    bit stimulus_done = 0;
    bit calm = 0;
    int errors = 0;
    longint cycles = 0;
    int in_gap = 0;
    int out_stall = 0;
    bit o_in_ready_seen = 0;
    int accepted_words = 0;
    int taken_words = 0;

    segment_normal_offset_points #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_end_x(i_end_x), .i_end_y(i_end_y),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_left_x(o_left_x), .o_left_y(o_left_y),
        .o_right_x(o_right_x), .o_right_y(o_right_y),
        .o_zero_length(o_zero_length)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [CW-1:0] halve_clamp(longint v);
        longint h;
        h = (v + 1) >>> 1;
        if (h < -(64'sd1 <<< (CW-1))) h = -(64'sd1 <<< (CW-1));
        if (h > (64'sd1 <<< (CW-1)) - 1) h = (64'sd1 <<< (CW-1)) - 1;
        return h[CW-1:0];
    endfunction

    function automatic offsets_t normal_offsets(segment_t s);
        offsets_t o;
        longint dx, dy, sumx, sumy, hx, hy;
        longint unsigned ax, ay, m, len;
        dx = longint'(s.ex) - longint'(s.sx);
        dy = longint'(s.ey) - longint'(s.sy);
        sumx = longint'(s.sx) + longint'(s.ex);
        sumy = longint'(s.sy) + longint'(s.ey);
        hx = 0;
        hy = 0;
        o.zero = (dx == 0) && (dy == 0);
        if (!o.zero) begin
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            m = ax > ay ? ax : ay;
            while (m < (64'd1 << 29)) begin
                ax <<= 1; ay <<= 1; m <<= 1;
            end
            while (m >= (64'd1 << 30)) begin
                ax >>= 1; ay >>= 1; m >>= 1;
            end
            len = int_sqrt(ax * ax + ay * ay);
            hx = ((ax << (FB + 1)) + len) / (2 * len);
            hy = ((ay << (FB + 1)) + len) / (2 * len);
            if (dx < 0) hx = -hx;
            if (dy < 0) hy = -hy;
        end
        o.lx = halve_clamp(sumx - hy);
        o.ly = halve_clamp(sumy + hx);
        o.rx = halve_clamp(sumx + hy);
        o.ry = halve_clamp(sumy - hx);
        return o;
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1: return CW'($urandom_range(0, 15) - 8);
            default: return CW'($urandom());
        endcase
    endfunction

    // segments actually handed to the block so far
    function automatic int issued_words();
        return taken_words;
    endfunction

    task automatic add_segment(int a, int b, int c, int d);
        segment_t s;
        s.sx = CW'(a); s.sy = CW'(b); s.ex = CW'(c); s.ey = CW'(d);
        pending_segments.push_back(s);
    endtask

    initial begin
        segment_t s;
        add_segment(0, 0, 0, 0);
        add_segment(32767, 32767, 32767, 32767);
        add_segment(-32768, -32768, -32768, -32768);
        add_segment(-32768, -32768, 32767, 32767);
        add_segment(32767, -32768, -32768, 32767);
        add_segment(-32768, 0, 32767, 0);
        add_segment(0, -32768, 0, 32767);
        add_segment(0, 0, 1, 0);
        add_segment(0, 0, 0, -1);
        add_segment(0, 0, 1, 1);
        add_segment(32767, 32767, 32766, 32767);
        add_segment(32767, 32767, 32767, 32766);
        add_segment(-32768, -32768, -32767, -32768);
        add_segment(-32768, -32768, -32768, -32767);
        add_segment(0, 0, 256, 0);
        add_segment(0, 0, 3, 4);
        add_segment(1, 1, 2, 2);
        add_segment(-1, 0, 0, 0);
        add_segment(32767, 0, -32768, 0);
        add_segment(0, 32767, 0, -32768);
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            s.sx = rand_coord();
            s.sy = rand_coord();
            case ($urandom_range(0, 9))
                0: begin s.ex = s.sx; s.ey = s.sy; end
                1: begin
                    s.ex = CW'(s.sx + $urandom_range(0, 6) - 3);
                    s.ey = s.sy;
                end
                2: begin
                    s.ex = s.sx;
                    s.ey = CW'(s.sy + $urandom_range(0, 6) - 3);
                end
                default: begin s.ex = rand_coord(); s.ey = rand_coord(); end
            endcase
            pending_segments.push_back(s);
        end
        stimulus_done = 1;
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (pending_segments.size() <= TAIL_WORDS) calm <= 1;
            if (i_in_valid && o_in_ready_seen) begin
                // word was taken at the last rising edge
            end
            if (!i_in_valid || o_in_ready_seen) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_segments.size() > 0) begin
                    segment_t s;
                    s = pending_segments.pop_front();
                    i_start_x <= s.sx; i_start_y <= s.sy;
                    i_end_x <= s.ex; i_end_y <= s.ey;
                    i_in_valid <= 1'b1;
                    expected_offsets.push_back(normal_offsets(s));
                    if (!calm && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 17);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ready for output side, in stall bursts
    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            out_stall <= $urandom_range(0, 16);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // input acceptance seen at the rising edge
    always @(posedge i_clk) o_in_ready_seen <= i_in_valid && o_in_ready && i_rst_n;

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            offsets_t e;
            if (accepted_words >= issued_words()) begin
                $display("%0t: result with nothing expected, got %h %h %h %h %b", $time,
                         o_left_x, o_left_y, o_right_x, o_right_y, o_zero_length);
                errors++;
            end else begin
                e = expected_offsets[accepted_words];
                if (e.lx !== o_left_x || e.ly !== o_left_y || e.rx !== o_right_x ||
                    e.ry !== o_right_y || e.zero !== o_zero_length) begin
                    $display("%0t: expected %h %h %h %h %b, got %h %h %h %h %b", $time,
                             e.lx, e.ly, e.rx, e.ry, e.zero, o_left_x, o_left_y,
                             o_right_x, o_right_y, o_zero_length);
                    errors++;
                end
            end
            accepted_words++;
        end
    end

    always @(posedge i_clk) if (i_rst_n && i_in_valid && o_in_ready) taken_words++;

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;
        wait (stimulus_done);
        while ((pending_segments.size() > 0 || i_in_valid ||
                accepted_words < taken_words) && cycles < CYCLE_LIMIT)
            @(posedge i_clk);
        if (cycles >= CYCLE_LIMIT) begin
            $display("segment_normal_offset_points test failed");
            $finish;
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            if (errors == 0 && accepted_words == taken_words)
                $display("segment_normal_offset_points test passed");
            else
                $display("segment_normal_offset_points test failed");
            $finish;
        end
    end
endmodule
`default_nettype wire
